// File: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rational arithmetic unit package
// operation codes and the packed command and result types
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] a_num;
		logic [30:0]        a_den;
		logic signed [31:0] b_num;
		logic [30:0]        b_den;
	} cmd_t;

	typedef struct packed {
		logic signed [63:0] res_num;
		logic [61:0]        res_den;
		logic signed [63:0] whole_part;
		logic [61:0]        rem_part;
		logic               div_by_zero;
	} res_t;

endpackage

// File: rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational arithmetic unit
// adds, subtracts, multiplies or divides two fractions and reduces the result
// ----------------------------------------------------------------------------
// latency depends on the operands: the sequence is three products, a set-up step, euclid steps on
// the shared 64-bit restoring divider, the three closing divisions (numerator, denominator,
// whole part) and an output step; a zero numerator skips the euclid steps and the reductions,
// and a zero denominator goes straight to the output
// one item at a time: busy stays high until the result strobe
// asynchronous active-low reset clears the sequencer; the receiver cannot stall
module rational_arithmetic_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rau_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output rau_pkg::res_t result
);
	import rau_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_PREP, S_GCD, S_RED_N, S_RED_D, S_WHOLE, S_OUT
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic signed [63:0] p1_q, p2_q;
	logic signed [63:0] num_q, den_q;
	logic               neg_q;
	logic [63:0]        m_q, d_q, x_q, y_q;

	// shared multiplier, one product a cycle
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;

	// shared bit-serial divider
	logic [63:0] dv_n_q, dv_d_q, dv_q_q;
	logic [64:0] dv_r_q;
	logic [6:0]  dv_cnt_q;
	logic        dv_run_q;
	logic [64:0] dv_trial;
	logic [64:0] dv_sub;

	assign mul_p    = mul_a * mul_b;
	assign dv_trial = {dv_r_q[63:0], dv_n_q[63]};
	assign dv_sub   = dv_trial - {1'b0, dv_d_q};

	always_comb begin
		mul_a = cmd_q.a_num;
		mul_b = $signed({1'b0, cmd_q.b_den});
		case (state_q)
			S_MUL1: begin
				if (cmd_q.mode == OP_MUL) begin
					mul_b = cmd_q.b_num;
				end
			end
			S_MUL2: begin
				mul_a = $signed({1'b0, cmd_q.a_den});
				if (cmd_q.mode == OP_DIV) begin
					mul_b = cmd_q.b_num;
				end else if (cmd_q.mode == OP_MUL) begin
					mul_b = $signed({1'b0, cmd_q.b_den});
				end else begin
					mul_b = cmd_q.b_num;
				end
			end
			default: begin
				mul_a = $signed({1'b0, cmd_q.a_den});
				mul_b = $signed({1'b0, cmd_q.b_den});
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done     <= 1'b0;
			dv_run_q <= 1'b0;
		end else begin
			done <= (state_q == S_OUT);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					p1_q    <= mul_p;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					p2_q    <= mul_p;
					state_q <= S_PREP;
				end
				S_PREP: begin
					// den from the third product (the second for a division), num from the first two (add, sub) or the first
					den_q <= (cmd_q.mode == OP_DIV) ? p2_q : mul_p;
					case (cmd_q.mode)
						OP_ADD:  num_q <= p1_q + p2_q;
						OP_SUB:  num_q <= p1_q - p2_q;
						default: num_q <= p1_q;
					endcase
					state_q <= S_GCD;
				end
				S_GCD: begin
					if (!dv_run_q && dv_cnt_q == 7'd0) begin
						// first visit: sign, magnitudes, special cases
						if (den_q == 64'sd0) begin
							result <= '{res_num: '0, res_den: '0, whole_part: '0,
								rem_part: '0, div_by_zero: 1'b1};
							state_q <= S_OUT;
						end else begin
							neg_q <= (num_q[63] != den_q[63]) && (num_q != 64'sd0);
							m_q   <= num_q[63] ? 64'd0 - num_q : num_q;
							d_q   <= (num_q == 64'sd0) ? 64'd1 :
								(den_q[63] ? 64'd0 - den_q : den_q);
							x_q   <= num_q[63] ? 64'd0 - num_q : num_q;
							y_q   <= den_q[63] ? 64'd0 - den_q : den_q;
							if (num_q == 64'sd0) begin
								state_q <= S_WHOLE;
							end
							dv_cnt_q <= 7'd1;
						end
					end else if (!dv_run_q) begin
						if (y_q == 64'd0) begin
							// x holds the gcd
							dv_n_q   <= m_q;
							dv_d_q   <= x_q;
							dv_r_q   <= '0;
							dv_cnt_q <= 7'd64;
							dv_run_q <= 1'b1;
							state_q  <= S_RED_N;
						end else begin
							dv_n_q   <= x_q;
							dv_d_q   <= y_q;
							dv_r_q   <= '0;
							dv_cnt_q <= 7'd64;
							dv_run_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase

			// divider iteration and completion handling
			if (dv_run_q) begin
				if (dv_cnt_q != 7'd0) begin
					if (!dv_sub[64]) begin
						dv_r_q <= dv_sub;
						dv_q_q <= {dv_q_q[62:0], 1'b1};
					end else begin
						dv_r_q <= dv_trial;
						dv_q_q <= {dv_q_q[62:0], 1'b0};
					end
					dv_n_q   <= {dv_n_q[62:0], 1'b0};
					dv_cnt_q <= dv_cnt_q - 7'd1;
				end else begin
					// the numerator reduction chains straight into the denominator one
					dv_run_q <= (state_q == S_RED_N);
					case (state_q)
						S_GCD: begin
							x_q      <= y_q;
							y_q      <= dv_r_q[63:0];
							dv_cnt_q <= 7'd1;
						end
						S_RED_N: begin
							m_q      <= dv_q_q;
							dv_n_q   <= d_q;
							dv_d_q   <= x_q;
							dv_r_q   <= '0;
							dv_cnt_q <= 7'd64;
							state_q  <= S_RED_D;
						end
						S_RED_D: begin
							d_q      <= dv_q_q;
							dv_cnt_q <= 7'd0;
							state_q  <= S_WHOLE;
						end
						S_WHOLE: begin
							result.res_num     <= neg_q ? 64'd0 - m_q : m_q;
							result.res_den     <= d_q[61:0];
							result.whole_part  <= neg_q ? 64'd0 - dv_q_q : dv_q_q;
							result.rem_part    <= dv_r_q[61:0];
							result.div_by_zero <= 1'b0;
							dv_cnt_q <= 7'd0;
							state_q  <= S_OUT;
						end
						default: ;
					endcase
				end
			end else if (state_q == S_WHOLE) begin
				dv_n_q   <= m_q;
				dv_d_q   <= d_q;
				dv_r_q   <= '0;
				dv_cnt_q <= 7'd64;
				dv_run_q <= 1'b1;
			end else if (state_q == S_OUT) begin
				state_q <= S_IDLE;
			end else if (state_q == S_IDLE) begin
				dv_cnt_q <= 7'd0;
			end
		end
	end

endmodule

// File: tb/tb_rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational arithmetic unit testbench
// drives directed and random fraction commands with random gaps and checks each
// reduced result, whole part and remainder against a behavioural calculation
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
	import rau_pkg::*;

	class fraction_scoreboard;
		res_t pending[$];
		int   mismatches;

		function res_t reduce_fraction(cmd_t c);
			res_t        r;
			logic signed [63:0] an, ad, bn, bd, num, den;
			logic [63:0] m, d, x, y, t, w, rm;
			logic        neg;
			an = c.a_num;
			ad = {33'd0, c.a_den};
			bn = c.b_num;
			bd = {33'd0, c.b_den};
			case (c.mode)
				OP_ADD: begin num = an * bd + ad * bn; den = ad * bd; end
				OP_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
				OP_MUL: begin num = an * bn; den = ad * bd; end
				default: begin num = an * bd; den = ad * bn; end
			endcase
			r = '0;
			if (den == 0) begin
				r.div_by_zero = 1'b1;
				return r;
			end
			neg = (num < 0) != (den < 0);
			m = (num < 0) ? -num : num;
			d = (den < 0) ? -den : den;
			if (m == 0) begin
				neg = 1'b0;
				d = 64'd1;
			end else begin
				x = m;
				y = d;
				while (y != 0) begin
					t = x % y;
					x = y;
					y = t;
				end
				m = m / x;
				d = d / x;
			end
			w = m / d;
			rm = m % d;
			r.res_num = neg ? -m : m;
			r.res_den = d[61:0];
			r.whole_part = neg ? -w : w;
			r.rem_part = rm[61:0];
			return r;
		endfunction

		function void note_command(cmd_t c);
			pending.push_back(reduce_fraction(c));
		endfunction

		function void check_result(res_t got);
			res_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
				return;
			end
			exp = pending.pop_front();
			if (got.res_num !== exp.res_num || got.res_den !== exp.res_den ||
				got.whole_part !== exp.whole_part || got.rem_part !== exp.rem_part ||
				got.div_by_zero !== exp.div_by_zero) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp %0d/%0d w%0d r%0d z%0b got %0d/%0d w%0d r%0d z%0b",
						exp.res_num, exp.res_den, exp.whole_part, exp.rem_part,
						exp.div_by_zero, got.res_num, got.res_den, got.whole_part,
						got.rem_part, got.div_by_zero);
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  start;
	cmd_t  cmd;
	logic  busy;
	logic  done;
	res_t  result;

	fraction_scoreboard sb;

	rational_arithmetic_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#400000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// results are only ever offered for one cycle
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	// start drops only when a gap follows, so back to back commands keep it high
	task automatic idle_gap();
		int n;
		if ($urandom_range(0, 2) == 0)
			return;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
		start <= 1'b0;
		cmd <= '0;
		repeat (n) @(negedge clk);
	endtask

	task automatic send_command(cmd_t c);
		cmd <= c;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_command(c);
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_num();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 20) - 10;
			1: return 32'sh7fffffff;
			2: return -32'sh7fffffff;
			3: return $signed($urandom_range(0, 2000)) - 1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic int rand_den();
		case ($urandom_range(0, 4))
			0: return $urandom_range(1, 12);
			1: return 32'h7fffffff;
			2: return $urandom_range(1, 3000);
			default: return $urandom_range(1, 32'h7fffffff);
		endcase
	endfunction

	function automatic cmd_t mk(logic [1:0] op, logic signed [31:0] an, int ad,
		logic signed [31:0] bn, int bd);
		cmd_t c;
		c.mode = op;
		c.a_num = an;
		c.a_den = 31'(ad);
		c.b_num = bn;
		c.b_den = 31'(bd);
		return c;
	endfunction

	initial begin
		cmd_t c;
		int   i;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: each operation, extremes, zero numerators, divide by zero
		send_command(mk(OP_ADD, 1, 2, 1, 3));
		send_command(mk(OP_SUB, 1, 2, 1, 2));
		send_command(mk(OP_MUL, -3, 4, 8, 9));
		send_command(mk(OP_DIV, 7, 3, -2, 5));
		send_command(mk(OP_DIV, 5, 7, 0, 3));
		send_command(mk(OP_DIV, 0, 1, 0, 1));
		send_command(mk(OP_ADD, 0, 9, 0, 4));
		send_command(mk(OP_MUL, 0, 5, -6, 7));
		send_command(mk(OP_ADD, 32'sh7fffffff, 32'h7fffffff, 32'sh7fffffff, 32'h7fffffff));
		send_command(mk(OP_SUB, -32'sh7fffffff, 1, 32'sh7fffffff, 1));
		send_command(mk(OP_MUL, 32'sh7fffffff, 1, 32'sh7fffffff, 1));
		send_command(mk(OP_MUL, -32'sh7fffffff, 1, 32'sh7fffffff, 32'h7fffffff));
		send_command(mk(OP_DIV, -32'sh7fffffff, 1, -32'sh7fffffff, 32'h7fffffff));
		send_command(mk(OP_DIV, 1, 32'h7fffffff, -1, 32'h7fffffff));
		send_command(mk(OP_ADD, 32'sh80000000, 1, 32'sh80000000, 1));
		send_command(mk(OP_MUL, 32'sh80000000, 3, 32'sh80000000, 5));
		send_command(mk(OP_DIV, 32'sh80000000, 32'h7fffffff, 32'sh80000000, 1));
		send_command(mk(OP_ADD, 5, 0, 3, 2));
		send_command(mk(OP_DIV, 5, 4, 3, 0));
		send_command(mk(OP_MUL, 5, 0, 3, 0));
		send_command(mk(OP_SUB, 32'shffffffff, 32'h55555555, 32'sh55555555, 32'h2aaaaaaa));

		for (i = 0; i < 530; i++) begin
			idle_gap();
			c = mk(2'($urandom_range(0, 3)), rand_num(), rand_den(), rand_num(), rand_den());
			if ($urandom_range(0, 30) == 0)
				c.b_num = 0;
			send_command(c);
		end
		start <= 1'b0;
		cmd <= '0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
